// ===== src/fdl_pkg.sv =====
// Package for the feedback delay line: default sizes, register indexes,
// reset values and gain limits. Used by src/feedback_delay_line.sv and the test bench; no dependencies.

package fdl_pkg;

	// Default sizes handed to the top level
	localparam int FDL_MAX_DELAY   = 131072;
	localparam int FDL_CHANNELS    = 2;
	localparam int FDL_SAMPLE_BITS = 24;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int DELAY_W    = 17;
	localparam int GAIN_W     = 16;
	localparam int FB_W       = 15;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIX      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WET      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRY      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd5;

	// Gain limits in Q1.15
	localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd32768;
	localparam logic [FB_W-1:0]   FB_MAX   = 15'd32440;

	// Register reset values
	localparam int               RST_DELAY    = 24000;
	localparam logic [FB_W-1:0]   RST_FEEDBACK = 15'd0;
	localparam logic [GAIN_W-1:0] RST_MIX      = 16'd16384;
	localparam logic [GAIN_W-1:0] RST_WET      = 16'd32768;
	localparam logic [GAIN_W-1:0] RST_DRY      = 16'd32768;

	// Rounding offset for a Q1.15 product (one half of the last bit kept)
	localparam int ROUND_HALF = 16384;

endpackage

// ===== src/feedback_delay_line.sv =====
// Feedback delay (echo) for interleaved audio channels, with a per-channel
// ring buffer and one shared multiplier under a small sequencer. Uses fdl_pkg.
//
// Channel   Signals                               Direction  Moves
// s_        s_tvalid s_tready s_tdata s_tuser    in         one sample request
// m_        m_tvalid m_tready m_tdata            out        one processed sample
// wr_       wr_en wr_index wr_data               in         register write
//
// An effect sample runs through address, store read, four passes through the
// shared multiplier, a result step and the output step before the next request
// is accepted. A bypassed sample goes straight to the output step.
// The store is never cleared; per-channel fill tracking makes unwritten
// entries read as zero, so the block is ready straight after reset.
// A stalled output holds the finished sample and the sequencer waits for it.

module feedback_delay_line
	import fdl_pkg::*;
#(
	parameter int MAX_DELAY   = FDL_MAX_DELAY,
	parameter int CHANNELS    = FDL_CHANNELS,
	parameter int SAMPLE_BITS = FDL_SAMPLE_BITS,
	localparam int DW         = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DW-1:0]         s_tdata,   // sample_in
	input  logic                  s_tuser,   // channel
	// Output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DW-1:0]         m_tdata,   // sample_out
	// Configuration writes
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	localparam int SB     = SAMPLE_BITS;
	localparam int PW     = $clog2(MAX_DELAY);
	localparam int DEPTH  = CHANNELS * MAX_DELAY;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PRW    = SB + GAIN_W + 1;
	localparam logic [PW-1:0] POS_LAST = PW'(MAX_DELAY - 1);
	localparam logic [PW-1:0] DLY_RST  =
		(RST_DELAY >= MAX_DELAY) ? PW'(MAX_DELAY - 1) : PW'(RST_DELAY);
	localparam logic signed [SB-1:0] SAT_HI = {1'b0, {(SB - 1){1'b1}}};
	localparam logic signed [SB-1:0] SAT_LO = {1'b1, {(SB - 1){1'b0}}};

	// Sequencer codes
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ADDR = 4'd1;
	localparam logic [3:0] ST_READ = 4'd2;
	localparam logic [3:0] ST_DRY  = 4'd3;
	localparam logic [3:0] ST_WET  = 4'd4;
	localparam logic [3:0] ST_FBK  = 4'd5;
	localparam logic [3:0] ST_MIX  = 4'd6;
	localparam logic [3:0] ST_SUM  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0]              state_q;
	logic [PW-1:0]           dly_q;
	logic [FB_W-1:0]         fbg_q;
	logic [GAIN_W-1:0]       mixg_q;
	logic [GAIN_W-1:0]       wetg_q;
	logic [GAIN_W-1:0]       dryg_q;
	logic                    enable_q;

	logic [PW-1:0]           wp_q [CHANNELS];
	logic                    wrapped_q [CHANNELS];
	logic [SB-1:0]           store_q [DEPTH];

	logic signed [SB-1:0]    x_q;
	logic                    ch_q;
	logic [PW-1:0]           rp_q;
	logic                    hit_q;
	logic [SB-1:0]           rd_q;
	logic signed [SB-1:0]    del_q;
	logic signed [SB-1:0]    dry_q;
	logic signed [SB-1:0]    wet1_q;
	logic signed [SB-1:0]    res_q;
	logic signed [SB-1:0]    out_q;
	logic                    out_valid_q;
	logic signed [PRW-1:0]   prod_q;

	logic [CW-1:0]           chi;
	logic [PW:0]             diff;
	logic [AW-1:0]           base;
	logic [AW-1:0]           rd_addr;
	logic [AW-1:0]           wr_addr;
	logic                    store_we;
	logic signed [SB-1:0]    mul_a;
	logic [GAIN_W-1:0]       mul_b;
	logic signed [PRW-1:0]   prod_rnd;
	logic signed [SB-1:0]    mul_r;
	logic signed [SB:0]      sum_fb;
	logic signed [SB:0]      sum_out;
	logic signed [SB-1:0]    fb_sat;
	logic signed [SB-1:0]    out_sat;
	logic                    in_acc;
	logic                    bypass;
	logic                    out_free;
	logic [31:0]             d_wide;

	assign chi      = CW'(ch_q);
	assign in_acc   = s_tvalid && s_tready;
	assign bypass   = !enable_q || (32'(s_tuser) >= 32'(CHANNELS));
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = DW'($unsigned(out_q));
	assign d_wide   = 32'(wr_data[DELAY_W-1:0]);

	// Read point lags the write point by the delay, wrapping round the ring.
	// A non-negative difference means the entry lies behind the fill front.
	assign diff = {1'b0, wp_q[chi]} - {1'b0, dly_q};

	// Store addresses: each channel owns one ring of MAX_DELAY entries
	assign base     = ch_q ? AW'(MAX_DELAY) : '0;
	assign rd_addr  = base + AW'(rp_q);
	assign wr_addr  = base + AW'(wp_q[chi]);
	assign store_we = (state_q == ST_MIX);

	// Operand selection for the shared multiplier
	always_comb begin
		mul_a = x_q;
		mul_b = dryg_q;
		case (state_q)
			ST_DRY: begin
				mul_a = x_q;
				mul_b = dryg_q;
			end
			ST_WET: begin
				mul_a = del_q;
				mul_b = wetg_q;
			end
			ST_FBK: begin
				mul_a = del_q;
				mul_b = GAIN_W'(fbg_q);
			end
			ST_MIX: begin
				mul_a = wet1_q;
				mul_b = mixg_q;
			end
			default: begin
				mul_a = x_q;
				mul_b = dryg_q;
			end
		endcase
	end

	// Round half up and drop fifteen fraction bits; every gain is at most one,
	// so the rounded product always fits the sample width.
	assign prod_rnd = prod_q + PRW'(ROUND_HALF);
	assign mul_r    = prod_rnd[SB+14:15];

	// Feedback and output sums, saturated to the sample range
	assign sum_fb  = {x_q[SB-1], x_q} + {mul_r[SB-1], mul_r};
	assign sum_out = {dry_q[SB-1], dry_q} + {mul_r[SB-1], mul_r};

	always_comb begin
		if (sum_fb > $signed({SAT_HI[SB-1], SAT_HI})) begin
			fb_sat = SAT_HI;
		end else if (sum_fb < $signed({SAT_LO[SB-1], SAT_LO})) begin
			fb_sat = SAT_LO;
		end else begin
			fb_sat = sum_fb[SB-1:0];
		end
		if (sum_out > $signed({SAT_HI[SB-1], SAT_HI})) begin
			out_sat = SAT_HI;
		end else if (sum_out < $signed({SAT_LO[SB-1], SAT_LO})) begin
			out_sat = SAT_LO;
		end else begin
			out_sat = sum_out[SB-1:0];
		end
	end

	// Configuration registers, clamped to their legal ranges when written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_q    <= DLY_RST;
			fbg_q    <= RST_FEEDBACK;
			mixg_q   <= RST_MIX;
			wetg_q   <= RST_WET;
			dryg_q   <= RST_DRY;
			enable_q <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				REG_DELAY: begin
					if (d_wide == 32'd0) begin
						dly_q <= PW'(1);
					end else if (d_wide >= 32'(MAX_DELAY)) begin
						dly_q <= POS_LAST;
					end else begin
						dly_q <= PW'(d_wide);
					end
				end
				REG_FEEDBACK: begin
					fbg_q <= (wr_data[FB_W-1:0] > FB_MAX) ? FB_MAX : wr_data[FB_W-1:0];
				end
				REG_MIX: begin
					mixg_q <= (wr_data[GAIN_W-1:0] > GAIN_ONE) ? GAIN_ONE : wr_data[GAIN_W-1:0];
				end
				REG_WET: begin
					wetg_q <= (wr_data[GAIN_W-1:0] > GAIN_ONE) ? GAIN_ONE : wr_data[GAIN_W-1:0];
				end
				REG_DRY: begin
					dryg_q <= (wr_data[GAIN_W-1:0] > GAIN_ONE) ? GAIN_ONE : wr_data[GAIN_W-1:0];
				end
				REG_ENABLE: begin
					enable_q <= wr_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer, write positions and fill tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				wp_q[i]      <= '0;
				wrapped_q[i] <= 1'b0;
			end
		end else begin
			// The output slot fills from the sequencer and empties when taken.
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= bypass ? ST_OUT : ST_ADDR;
					end
				end
				ST_ADDR: state_q <= ST_READ;
				ST_READ: state_q <= ST_DRY;
				ST_DRY:  state_q <= ST_WET;
				ST_WET:  state_q <= ST_FBK;
				ST_FBK:  state_q <= ST_MIX;
				ST_MIX: begin
					// The feedback sample goes into the store here; move on
					if (wp_q[chi] == POS_LAST) begin
						wp_q[chi]      <= '0;
						wrapped_q[chi] <= 1'b1;
					end else begin
						wp_q[chi] <= wp_q[chi] + PW'(1);
					end
					state_q <= ST_SUM;
				end
				ST_SUM: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Data path registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * $signed({1'b0, mul_b});
		if (in_acc) begin
			x_q   <= s_tdata[SB-1:0];
			ch_q  <= s_tuser;
			res_q <= s_tdata[SB-1:0];
		end
		if (state_q == ST_ADDR) begin
			rp_q  <= diff[PW] ? (diff[PW-1:0] + PW'(MAX_DELAY)) : diff[PW-1:0];
			hit_q <= wrapped_q[chi] || !diff[PW];
		end
		if (state_q == ST_DRY) begin
			del_q <= hit_q ? rd_q : '0;
		end
		if (state_q == ST_WET) begin
			dry_q <= mul_r;
		end
		if (state_q == ST_FBK) begin
			wet1_q <= mul_r;
		end
		if (state_q == ST_SUM) begin
			res_q <= out_sat;
		end
		if (state_q == ST_OUT && out_free) begin
			out_q <= res_q;
		end
	end

	// Delay store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		rd_q <= store_q[rd_addr];
		if (store_we) begin
			store_q[wr_addr] <= fb_sat;
		end
	end

	// The feedback write never lands on the entry being read back
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX) |-> (wr_addr != rd_addr))
		else $error("delay store write hits the read entry");

	// The delay register stays within one and the ring length less one
	a_delay_range: assert property (@(posedge clk) disable iff (!arst_n)
		(dly_q != '0) && (dly_q <= POS_LAST))
		else $error("delay length out of range");

	// An accepted request starts the effect or goes straight to the output
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> ((state_q == ST_ADDR) || (state_q == ST_OUT)))
		else $error("accepted request not started");

	// A finished sample waits while the output slot is still taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && out_valid_q && !m_tready |=>
		(state_q == ST_OUT) && out_valid_q && $stable(out_q))
		else $error("output overwritten while stalled");

	// The write position moves on once per effect sample
	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX) |=>
		(wp_q[chi] == (($past(wp_q[chi]) == POS_LAST) ? '0 : $past(wp_q[chi]) + PW'(1))))
		else $error("write position did not advance");

endmodule

// ===== tb/sv/echo_checker.sv =====
`timescale 1ns / 1ps
// Checker for the feedback delay line: watches the sample, result and register
// channels, predicts every processed sample and compares it on the output stream.
// Depends on fdl_pkg only.

module echo_checker
	import fdl_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [FDL_SAMPLE_BITS-1:0] s_tdata,   // sample_in
	input  logic                       s_tuser,   // channel
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [FDL_SAMPLE_BITS-1:0] m_tdata,   // sample_out
	input  logic                       wr_en,
	input  logic [CFG_IDX_W-1:0]       wr_index,
	input  logic [CFG_DATA_W-1:0]      wr_data,
	output int                         mismatches,
	output int                         outstanding,
	output int                         checked
);

	localparam int     SB         = FDL_SAMPLE_BITS;
	localparam longint SAMPLE_MAX = (longint'(1) << (SB - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

	// Shadow copy of the register file
	logic [DELAY_W-1:0] delay_reg;
	logic [FB_W-1:0]    feedback_reg;
	logic [GAIN_W-1:0]  mix_reg;
	logic [GAIN_W-1:0]  wet_reg;
	logic [GAIN_W-1:0]  dry_reg;
	logic               enable_reg;

	// Echo lines, keyed by channel and position; an entry never written reads as zero.
	logic signed [SB-1:0] line_store [int];
	int unsigned          write_pos [FDL_CHANNELS];
	logic [SB-1:0]        expected_out [$];
	logic [SB-1:0]        oldest;

	// Q1.15 product, rounded half up (arithmetic shift floors negative values).
	function automatic longint gain_mul(input longint v, input longint g);
		return (v * g + ROUND_HALF) >>> 15;
	endfunction

	function automatic longint clip_sample(input longint v);
		if (v > SAMPLE_MAX)
			return SAMPLE_MAX;
		if (v < SAMPLE_MIN)
			return SAMPLE_MIN;
		return v;
	endfunction

	function automatic longint cap_gain(input longint g, input longint lim);
		return (g > lim) ? lim : g;
	endfunction

	// Works out one processed sample and updates the echo line of its channel.
	function automatic logic [SB-1:0] predict_echo(input logic [SB-1:0] raw, input logic ch);
		longint      x;
		longint      delayed;
		longint      dry;
		longint      wet;
		longint      y;
		longint      fb;
		int unsigned d;
		int unsigned wp;
		int unsigned rp;
		int          key;
		x = longint'($signed(raw));
		// Bypass leaves the lines and positions untouched.
		if (!enable_reg)
			return raw;
		d = delay_reg;
		if (d == 0)
			d = 1;
		if (d >= FDL_MAX_DELAY)
			d = FDL_MAX_DELAY - 1;
		wp = write_pos[ch];
		rp = (wp + FDL_MAX_DELAY - d) % FDL_MAX_DELAY;
		key = int'(ch) * FDL_MAX_DELAY + int'(rp);
		delayed = line_store.exists(key) ? longint'(line_store[key]) : 0;
		dry = gain_mul(x, cap_gain(dry_reg, GAIN_ONE));
		wet = gain_mul(gain_mul(delayed, cap_gain(wet_reg, GAIN_ONE)), cap_gain(mix_reg, GAIN_ONE));
		y = clip_sample(dry + wet);
		fb = clip_sample(x + gain_mul(delayed, cap_gain(feedback_reg, FB_MAX)));
		line_store[int'(ch) * FDL_MAX_DELAY + int'(wp)] = fb[SB-1:0];
		write_pos[ch] = (wp + 1) % FDL_MAX_DELAY;
		return y[SB-1:0];
	endfunction

	// Track register writes, predict on each accepted request and compare each result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_reg = DELAY_W'(RST_DELAY);
			feedback_reg = RST_FEEDBACK;
			mix_reg = RST_MIX;
			wet_reg = RST_WET;
			dry_reg = RST_DRY;
			enable_reg = 1'b1;
			line_store.delete();
			foreach (write_pos[i])
				write_pos[i] = 0;
			expected_out.delete();
			mismatches <= 0;
			outstanding <= 0;
			checked <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_DELAY:    delay_reg = wr_data[DELAY_W-1:0];
					REG_FEEDBACK: feedback_reg = wr_data[FB_W-1:0];
					REG_MIX:      mix_reg = wr_data[GAIN_W-1:0];
					REG_WET:      wet_reg = wr_data[GAIN_W-1:0];
					REG_DRY:      dry_reg = wr_data[GAIN_W-1:0];
					REG_ENABLE:   enable_reg = wr_data[0];
					default:      ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_out.push_back(predict_echo(s_tdata, s_tuser));
			if (m_tvalid && m_tready) begin
				if (expected_out.size() == 0) begin
					$display("%0t: unexpected sample_out: expected none, got %0d",
						$time, $signed(m_tdata));
					mismatches <= mismatches + 1;
				end else begin
					oldest = expected_out.pop_front();
					checked <= checked + 1;
					if (m_tdata !== oldest) begin
						$display("%0t: sample_out mismatch: expected %0d, got %0d",
							$time, $signed(oldest), $signed(m_tdata));
						mismatches <= mismatches + 1;
					end
				end
			end
			outstanding <= expected_out.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top level of the feedback delay line test: clock, reset, sample stimulus,
// register settings and the verdict. Depends on fdl_pkg, echo_checker and the block.

module testbench;
	import fdl_pkg::*;

	localparam int SB          = FDL_SAMPLE_BITS;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 140;
	localparam logic [SB-1:0] PEAK_POS = {1'b0, {(SB - 1){1'b1}}};
	localparam logic [SB-1:0] PEAK_NEG = {1'b1, {(SB - 1){1'b0}}};
	localparam logic [CFG_DATA_W-1:0] CFG_ALL_ONES = {CFG_DATA_W{1'b1}};
	// Indexes past the register file; writes there must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [SB-1:0]         s_tdata;   // sample_in
	logic                  s_tuser;   // channel
	logic                  m_tvalid;
	logic                  m_tready;
	logic [SB-1:0]         m_tdata;   // sample_out
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	int mismatches;
	int outstanding;
	int checked;
	int idle_pct;
	int stall_pct;
	int samples_sent;
	int settings_used;

	feedback_delay_line dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	echo_checker echo_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked)
	);

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Output side: stall at the rate of the current phase.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Guard against a hang.
	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

	// One register write; the caller lowers wr_en after its last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] delay, input logic [CFG_DATA_W-1:0] fb,
		input logic [CFG_DATA_W-1:0] mix, input logic [CFG_DATA_W-1:0] wet,
		input logic [CFG_DATA_W-1:0] dry, input logic [CFG_DATA_W-1:0] en);
		write_reg(REG_DELAY, delay);
		write_reg(REG_FEEDBACK, fb);
		write_reg(REG_MIX, mix);
		write_reg(REG_WET, wet);
		write_reg(REG_DRY, dry);
		write_reg(REG_ENABLE, en);
		wr_en <= 1'b0;
		settings_used++;
	endtask

	// Offers one sample request after a random gap and returns once it is taken.
	task automatic send_sample(input logic [SB-1:0] smp, input logic ch);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tuser <= ch;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		samples_sent++;
	endtask

	// Stops sending and waits until every predicted sample has come out.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	function automatic logic [SB-1:0] pick_sample();
		case ($urandom_range(9))
			0:       return PEAK_POS;
			1:       return PEAK_NEG;
			2:       return SB'($urandom_range(511)) - SB'(256);
			default: return SB'($urandom());
		endcase
	endfunction

	// Gains mostly in range, some at the extremes and some above unity.
	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(5))
			0:       return '0;
			1:       return CFG_DATA_W'(GAIN_ONE);
			2:       return CFG_DATA_W'($urandom_range(65535));
			3:       return CFG_DATA_W'($urandom());
			default: return CFG_DATA_W'($urandom_range(32768));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_delay();
		case ($urandom_range(7))
			0:       return '0;
			1:       return CFG_DATA_W'($urandom_range(1, 131071));
			2:       return CFG_ALL_ONES;
			default: return CFG_DATA_W'($urandom_range(1, 40));
		endcase
	endfunction

	// Stimulus
	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		arst_n = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		samples_sent = 0;
		settings_used = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero delay acts as one, oversize gains clamp, spare indexes do nothing.
		configure('0, CFG_ALL_ONES, CFG_ALL_ONES, CFG_DATA_W'(GAIN_ONE),
			CFG_DATA_W'(GAIN_ONE), CFG_DATA_W'(1));
		write_reg(REG_SPARE_A, '0);
		write_reg(REG_SPARE_B, '0);
		wr_en <= 1'b0;
		// Repeated peaks drive both the output and the written-back sum into saturation.
		send_sample(PEAK_POS, 1'b0);
		send_sample(PEAK_POS, 1'b0);
		send_sample(PEAK_POS, 1'b0);
		send_sample(PEAK_NEG, 1'b1);
		send_sample(PEAK_NEG, 1'b1);
		send_sample(PEAK_NEG, 1'b1);
		send_sample('0, 1'b0);
		send_sample('1, 1'b1);
		send_sample(SB'(1), 1'b0);
		send_sample(24'h555555, 1'b1);
		send_sample(24'hAAAAAA, 1'b0);
		wait_drained();

		// Bypass: samples pass unchanged and the lines stay as they are.
		write_reg(REG_ENABLE, '0);
		wr_en <= 1'b0;
		send_sample(PEAK_POS, 1'b0);
		send_sample(PEAK_NEG, 1'b1);
		send_sample(24'h0F0F0F, 1'b0);
		wait_drained();

		// Tiny gains exercise rounding of negative and positive products.
		write_reg(REG_ENABLE, CFG_DATA_W'(1));
		write_reg(REG_DRY, CFG_DATA_W'(1));
		write_reg(REG_MIX, CFG_DATA_W'(1));
		wr_en <= 1'b0;
		send_sample(SB'(1), 1'b0);
		send_sample('1, 1'b1);
		send_sample(PEAK_POS, 1'b0);

		// Random phases, each under its own setting and idling pattern.
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			case (p)
				0: configure(CFG_DATA_W'(1), '0, '0, '0, '0, CFG_DATA_W'(1));
				1: configure(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES,
					CFG_ALL_ONES, CFG_ALL_ONES);
				2: configure(CFG_DATA_W'(2), CFG_DATA_W'(FB_MAX), CFG_DATA_W'(GAIN_ONE),
					CFG_DATA_W'(GAIN_ONE), CFG_DATA_W'(GAIN_ONE), CFG_DATA_W'(1));
				default: configure(pick_delay(),
					($urandom_range(3) == 0) ? CFG_DATA_W'(FB_MAX) : CFG_DATA_W'($urandom()),
					pick_gain(), pick_gain(), pick_gain(),
					CFG_DATA_W'($urandom_range(5) != 0));
			endcase
			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 55;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 55;
				end
				default: begin
					idle_pct = 12;
					stall_pct = 12;
				end
			endcase
			repeat (PHASE_ITEMS)
				send_sample(pick_sample(), 1'($urandom_range(1)));
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Sent %0d samples under %0d register settings; %0d results compared.",
			samples_sent, settings_used, checked);
		$display("Covered bypass, zero and longest delays, clamped gains and output stalls.");
		if (mismatches == 0 && outstanding == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/fdl_pkg.sv
src/feedback_delay_line.sv
tb/sv/echo_checker.sv
tb/sv/testbench.sv
